// ===== sv/lhnb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhnb_pkg: shared types and constants for the luma histogram
// Operation codes, controller states and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package lhnb_pkg;

    // operation carried in tuser
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // fixed field widths
    localparam int LUMA_W      = 8;
    localparam int SCALE_W     = 11;
    localparam int COUNT_OUT_W = 32;
    localparam int QUOT_W      = 11;
    localparam int DIV_STEP_W  = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } lhnb_state_t;

    typedef struct packed {
        logic clr_wr;    // write zero at the clear pointer
        logic capture;   // take the input beat and start the bin read
        logic upd_wr;    // write back the incremented count
        logic mul_en;    // latch count and scale * count
        logic div_step;  // one restoring division step
        logic out_load;  // load the result register
    } lhnb_cmd_t;

    typedef struct packed {
        logic clr_last;  // clear pointer at the last bin
        logic div_last;  // final quotient bit in progress
        logic out_busy;  // result register still holds an untaken beat
    } lhnb_sts_t;

endpackage

// ===== sv/luma_histogram_normalized_bars.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_histogram_normalized_bars: 256-bin luma histogram with bar heights
// Saturating bin counters accumulated across frames, a running peak, and
// readout of one bin with height floor(scale * count / peak).
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | tuser: operation; tdata: luma, bin
//  m_      | out | m_tvalid / m_tready | tdata: bin_echo, bin_count, height
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_data: bar_scale_height
//
// An accumulate beat is a counter RAM read, then a write-back.
// A readout beat is a read, a multiply, 11 divider steps
// (one quotient bit each) and a result load.
// After reset a clearing pass zeroes all BIN_COUNT bins of the counter RAM,
// one bin per cycle, with s_tready low; configuration writes are taken.
// A readout holds in its final cycle while the result register is full and
// m_tready is low; new beats are accepted while a result waits.
// ----------------------------------------------------------------------------
module luma_histogram_normalized_bars #(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // [0] operation
    input  logic [15:0] s_tdata,    // [7:0] luma_sample, [15:8] bin_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [7:0] bin_echo, [39:8] bin_count,
                                    // [50:40] bar_height, [55:51] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data    // [10:0] bar_scale_height
);

    lhnb_pkg::lhnb_cmd_t cmd;
    lhnb_pkg::lhnb_sts_t sts;

    // scale register always accepts a write
    assign cfg_ready = 1'b1;

    lhnb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_op    (s_tuser),
        .s_tready(s_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    lhnb_datapath #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_op     (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/lhnb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhnb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lhnb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/lhnb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhnb_ctrl: histogram sequencer
// Runs the clearing pass, then steps each beat through read-modify-write or
// through multiply, eleven division steps and result hand-off.
// ----------------------------------------------------------------------------
module lhnb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_op,
    output logic                s_tready,
    output lhnb_pkg::lhnb_cmd_t cmd,
    input  lhnb_pkg::lhnb_sts_t sts
);

    lhnb_pkg::lhnb_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lhnb_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lhnb_pkg::ST_CLEAR: begin
                if (sts.clr_last) state_next = lhnb_pkg::ST_IDLE;
            end
            lhnb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_op == lhnb_pkg::OP_READ) ? lhnb_pkg::ST_MUL
                                                              : lhnb_pkg::ST_UPDATE;
                end
            end
            lhnb_pkg::ST_UPDATE: state_next = lhnb_pkg::ST_IDLE;
            lhnb_pkg::ST_MUL:    state_next = lhnb_pkg::ST_DIV;
            lhnb_pkg::ST_DIV: begin
                if (sts.div_last) state_next = lhnb_pkg::ST_DONE;
            end
            lhnb_pkg::ST_DONE: begin
                if (!sts.out_busy) state_next = lhnb_pkg::ST_IDLE;
            end
            default: state_next = lhnb_pkg::ST_CLEAR;
        endcase
    end

    // command decode
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            lhnb_pkg::ST_CLEAR:  cmd.clr_wr = 1'b1;
            lhnb_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            lhnb_pkg::ST_UPDATE: cmd.upd_wr   = 1'b1;
            lhnb_pkg::ST_MUL:    cmd.mul_en   = 1'b1;
            lhnb_pkg::ST_DIV:    cmd.div_step = 1'b1;
            lhnb_pkg::ST_DONE:   cmd.out_load = !sts.out_busy;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    // at most one datapath action per cycle
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(cmd))
        else $error("lhnb_ctrl: more than one datapath command active");

    // a readout reaches the multiply step right after its beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && s_op == lhnb_pkg::OP_READ) |=> cmd.mul_en)
        else $error("lhnb_ctrl: readout beat did not start the multiply");

    // hold off input beats during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !s_tready)
        else $error("lhnb_ctrl: input ready during the clearing pass");

endmodule

// ===== sv/lhnb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhnb_datapath: bin storage, peak tracking and bar height divider
// Holds the counter RAM, the peak register, the scale register, a
// multiplier stage, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module lhnb_datapath #(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lhnb_pkg::lhnb_cmd_t cmd,
    output lhnb_pkg::lhnb_sts_t sts,
    input  logic                s_op,
    input  logic [15:0]         s_tdata,
    input  logic                cfg_valid,
    input  logic [lhnb_pkg::SCALE_W-1:0] cfg_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [55:0]         m_tdata
);

    localparam int IDX_W  = $clog2(BIN_COUNT);
    localparam int CW     = COUNT_WIDTH;
    localparam int SW     = lhnb_pkg::SCALE_W;
    localparam int QW     = lhnb_pkg::QUOT_W;
    localparam int PROD_W = SW + CW;
    localparam int LW     = lhnb_pkg::LUMA_W;
    localparam int OW     = lhnb_pkg::COUNT_OUT_W;
    localparam int STW    = lhnb_pkg::DIV_STEP_W;

    logic [LW-1:0]    in_luma, in_sel;
    logic             in_luma_ok, in_sel_ok;
    logic [IDX_W-1:0] in_luma_idx, in_sel_idx;

    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [IDX_W-1:0]  luma_idx_reg;
    logic              luma_ok_reg;
    logic [LW-1:0]     sel_reg;
    logic              sel_ok_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     peak_reg;
    logic [SW-1:0]     scale_reg;
    logic [PROD_W-1:0] rem_reg, dsr_reg;
    logic [QW-1:0]     quot_reg;
    logic [STW-1:0]    step_reg;

    logic              out_valid_reg;
    logic [LW-1:0]     out_echo_reg;
    logic [OW-1:0]     out_count_reg;
    logic [SW-1:0]     out_height_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [CW-1:0]     ram_wdata, ram_rdata;
    logic [CW-1:0]     inc_val, cnt_sel;
    logic [PROD_W-1:0] prod;

    // unpack the beat and check bin ranges
    assign in_luma     = s_tdata[7:0];
    assign in_sel      = s_tdata[15:8];
    assign in_luma_ok  = ({24'd0, in_luma} < 32'(BIN_COUNT));
    assign in_sel_ok   = ({24'd0, in_sel} < 32'(BIN_COUNT));
    assign in_luma_idx = IDX_W'({{IDX_W{1'b0}}, in_luma});
    assign in_sel_idx  = IDX_W'({{IDX_W{1'b0}}, in_sel});

    // saturating increment and readout masking
    assign inc_val = (ram_rdata == {CW{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;
    assign cnt_sel = sel_ok_reg ? ram_rdata : '0;
    assign prod    = {{CW{1'b0}}, scale_reg} * {{SW{1'b0}}, cnt_sel};

    // counter RAM ports
    assign ram_raddr = (s_op == lhnb_pkg::OP_READ) ? in_sel_idx : in_luma_idx;
    assign ram_we    = cmd.clr_wr || (cmd.upd_wr && luma_ok_reg);
    assign ram_waddr = cmd.clr_wr ? clr_cnt_reg : luma_idx_reg;
    assign ram_wdata = cmd.clr_wr ? '0 : inc_val;

    lhnb_ram #(
        .WIDTH(CW),
        .DEPTH(BIN_COUNT)
    ) u_bins (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.capture),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // control registers: clear pointer, peak, scale, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            peak_reg      <= '0;
            scale_reg     <= lhnb_pkg::SCALE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.upd_wr && luma_ok_reg && (inc_val > peak_reg)) peak_reg <= inc_val;
            if (cfg_valid) scale_reg <= cfg_data;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // capture the beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            luma_idx_reg <= in_luma_idx;
            luma_ok_reg  <= in_luma_ok;
            sel_reg      <= in_sel;
            sel_ok_reg   <= in_sel_ok;
        end
    end

    // multiply, then restoring division one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            count_reg <= cnt_sel;
            rem_reg   <= prod;
            dsr_reg   <= PROD_W'({{SW{1'b0}}, peak_reg}) << (QW - 1);
            quot_reg  <= '0;
            step_reg  <= STW'(QW - 1);
        end else if (cmd.div_step) begin
            if (rem_reg >= dsr_reg) begin
                rem_reg  <= rem_reg - dsr_reg;
                quot_reg <= {quot_reg[QW-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[QW-2:0], 1'b0};
            end
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_echo_reg   <= sel_reg;
            out_count_reg  <= OW'({{OW{1'b0}}, count_reg});
            out_height_reg <= (peak_reg == '0) ? '0 : SW'(quot_reg);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == IDX_W'(BIN_COUNT - 1));
    assign sts.div_last = (step_reg == '0);
    assign sts.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_height_reg, out_count_reg, out_echo_reg};

    // a bin read never exceeds the running peak
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |=> (count_reg <= peak_reg))
        else $error("lhnb_datapath: bin count above peak");

    // peak follows every written count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.upd_wr && luma_ok_reg) |=> (peak_reg >= $past(inc_val)))
        else $error("lhnb_datapath: peak missed an update");

    // remainder stays below twice the shifted divisor, so the quotient fits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && peak_reg != '0) |-> (rem_reg < {dsr_reg, 1'b0}))
        else $error("lhnb_datapath: division remainder out of range");

endmodule
